/* rtl/core/mangled_symbol_scanner_defines.svh */
// Assertion macros used by the scanner core.
`ifndef MANGLED_SYMBOL_SCANNER_DEFINES_SVH
`define MANGLED_SYMBOL_SCANNER_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define MSS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define MSS_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

/* rtl/core/msscan_pkg.sv */
// Types, constants and the macro prefix pattern of the mangled symbol scanner.
`timescale 1ns / 1ps
`default_nettype none
package msscan_pkg;

  localparam int LinePositionsDef = 4096;
  localparam int StartW           = 12;
  localparam int EndW             = 13;
  localparam int MacroLen         = 14;
  localparam int MacroProgW       = 4;
  localparam int QueueDepth       = 2;

  // "@__swiftmacro_" byte by byte
  localparam logic [7:0] MacroPat [MacroLen] = '{
    8'h40, 8'h5F, 8'h5F, 8'h73, 8'h77, 8'h69, 8'h66,
    8'h74, 8'h6D, 8'h61, 8'h63, 8'h72, 8'h6F, 8'h5F
  };

  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChAt     = 8'h40;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChBigT   = 8'h54;
  localparam logic [7:0] ChBigS   = 8'h53;
  localparam logic [7:0] ChSmallS = 8'h73;
  localparam logic [7:0] ChSmallE = 8'h65;

  typedef enum logic [1:0] {
    PhIdle   = 2'd0,
    PhUnder  = 2'd1,
    PhDollar = 2'd2,
    PhFound  = 2'd3
  } phase_t;

  // Classified byte handed from the front end to the scanner core
  typedef struct packed {
    logic                is_under;
    logic                is_dollar;
    logic                is_at;
    logic                is_t;
    logic                is_sse;
    logic                is_body;
    logic [MacroLen-1:0] pat_hit;
    logic                last;
  } cls_t;

endpackage
`default_nettype wire

/* rtl/core/msscan_if.sv */
// Valid/ready channel interfaces for text bytes and found spans.
`timescale 1ns / 1ps
`default_nettype none
interface msscan_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       line_end;

  modport source (output valid, output char_byte, output line_end, input ready);
  modport sink   (input valid, input char_byte, input line_end, output ready);
endinterface

interface msscan_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] span_start;
  logic [12:0] span_end;
  logic        long_line;

  modport source (output valid, output span_start, output span_end, output long_line,
                  input ready);
  modport sink   (input valid, input span_start, input span_end, input long_line,
                  output ready);
endinterface
`default_nettype wire

/* rtl/core/msscan_front.sv */
// Front end: accepts text bytes and classifies them for the scanner core.
`timescale 1ns / 1ps
`default_nettype none
module msscan_front (
  msscan_in_if.sink           in_bus,
  output logic                push_valid,
  output msscan_pkg::cls_t    push_data,
  input  logic                push_ready
);
  import msscan_pkg::*;

  logic [7:0] c;
  logic       is_alpha;
  logic       is_digit;

  assign c = in_bus.char_byte;

  assign is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  assign is_digit = (c >= 8'h30) && (c <= 8'h39);

  // Byte class flags
  always_comb begin
    push_data.is_under  = (c == ChUnder);
    push_data.is_dollar = (c == ChDollar);
    push_data.is_at     = (c == ChAt);
    push_data.is_t      = (c == ChBigT);
    push_data.is_sse    = (c == ChBigS) || (c == ChSmallS) || (c == ChSmallE);
    push_data.is_body   = is_alpha || is_digit || (c == ChUnder) ||
                          (c == ChDollar) || (c == ChDot);
    push_data.last      = in_bus.line_end;
    for (int k = 0; k < MacroLen; k++) begin
      push_data.pat_hit[k] = (c == MacroPat[k]);
    end
  end

  assign push_valid   = in_bus.valid;
  assign in_bus.ready = push_ready;

endmodule
`default_nettype wire

/* rtl/core/msscan_fifo.sv */
// Two-entry queue between the front end and the scanner core.
`timescale 1ns / 1ps
`default_nettype none
module msscan_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  msscan_pkg::cls_t push_data,
  output logic             push_ready,
  output logic             pop_valid,
  output msscan_pkg::cls_t pop_data,
  input  logic             pop_ready
);
  import msscan_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  cls_t            mem_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count_r != CntW'(QueueDepth));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/msscan_back.sv */
// Scanner core: phase machine, macro prefix tracker, offsets and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "mangled_symbol_scanner_defines.svh"
module msscan_back #(
  parameter int LINE_POSITIONS = msscan_pkg::LinePositionsDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  input  msscan_pkg::cls_t pop_data,
  output logic             pop_ready,
  msscan_out_if.source     out_bus
);
  import msscan_pkg::*;

  localparam int OffW = $clog2(LINE_POSITIONS + 1);
  localparam int BegW = $clog2(LINE_POSITIONS);

  phase_t                phase_r, phase_nxt;
  logic [BegW-1:0]       begin_r, begin_nxt;
  logic [OffW-1:0]       off_r, off_nxt;
  logic [MacroProgW-1:0] prog_r, prog_nxt;
  logic                  body_r, body_nxt;
  logic                  sat_r, sat_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [StartW-1:0]     out_start_r, out_start_nxt;
  logic [EndW-1:0]       out_end_r, out_end_nxt;
  logic                  out_long_r, out_long_nxt;

  cls_t                  cl;
  logic                  take;
  logic                  at_lim;
  logic [BegW-1:0]       pos;
  logic                  consumed;
  logic                  start_cand;
  logic                  emit;
  logic [OffW-1:0]       emit_end;

  assign cl        = pop_data;
  assign pop_ready = !out_valid_r || out_bus.ready;
  assign take      = pop_valid && pop_ready;
  assign at_lim    = (off_r == OffW'(LINE_POSITIONS));
  assign pos       = at_lim ? BegW'(LINE_POSITIONS - 1) : BegW'(off_r);

  // Next state of the scan, one byte per beat
  always_comb begin
    phase_nxt  = phase_r;
    begin_nxt  = begin_r;
    off_nxt    = off_r;
    prog_nxt   = prog_r;
    body_nxt   = body_r;
    sat_nxt    = sat_r;
    consumed   = 1'b0;
    start_cand = 1'b0;
    emit       = 1'b0;
    emit_end   = off_r;
    if (take) begin
      if (at_lim) begin
        sat_nxt = 1'b1;
      end

      // body bytes extend a found span, anything else closes it
      if (phase_r == PhFound) begin
        if (cl.is_body) begin
          body_nxt = 1'b1;
          consumed = 1'b1;
        end else begin
          if (body_r) begin
            emit     = 1'b1;
            emit_end = off_r;
          end
          phase_nxt = PhIdle;
          body_nxt  = 1'b0;
        end
      end

      // prefix search; a closing byte is rescanned from idle
      if (!consumed) begin
        unique case (phase_nxt)
          PhIdle: begin
            if (cl.is_under) begin
              phase_nxt = PhUnder;
              begin_nxt = pos;
            end else if (cl.is_dollar) begin
              phase_nxt = PhDollar;
              begin_nxt = pos;
            end else if (cl.is_at) begin
              start_cand = 1'b1;
            end
          end
          PhUnder: begin
            if (cl.is_t) begin
              phase_nxt = PhFound;
              body_nxt  = 1'b0;
            end else if (cl.is_dollar) begin
              phase_nxt = PhDollar;
            end else if (cl.is_under) begin
              begin_nxt = pos;
            end else begin
              phase_nxt = PhIdle;
            end
          end
          PhDollar, PhFound: begin
            if (cl.is_sse) begin
              phase_nxt = PhFound;
              body_nxt  = 1'b0;
            end else if (cl.is_under) begin
              phase_nxt = PhUnder;
              begin_nxt = pos;
            end else if (cl.is_dollar) begin
              begin_nxt = pos;
            end else begin
              phase_nxt = PhIdle;
            end
          end
        endcase
      end

      // macro prefix tracker runs beside the phase machine
      if (start_cand) begin
        prog_nxt = MacroProgW'(1);
      end else if ((prog_r != '0) && (prog_r < MacroProgW'(MacroLen)) &&
                   cl.pat_hit[prog_r]) begin
        prog_nxt = prog_r + 1'b1;
      end else begin
        prog_nxt = '0;
      end

      if (prog_nxt == MacroProgW'(MacroLen)) begin
        prog_nxt  = '0;
        phase_nxt = PhFound;
        body_nxt  = 1'b0;
        if (sat_nxt) begin
          begin_nxt = BegW'(LINE_POSITIONS - 1);
        end else if (off_r >= OffW'(MacroLen - 1)) begin
          begin_nxt = BegW'(off_r - OffW'(MacroLen - 1));
        end else begin
          begin_nxt = '0;
        end
      end

      // line end flushes an open span and clears per-line state
      if (cl.last) begin
        if (!emit && (phase_nxt == PhFound) && body_nxt) begin
          emit     = 1'b1;
          emit_end = at_lim ? off_r : off_r + 1'b1;
        end
        phase_nxt = PhIdle;
        begin_nxt = '0;
        off_nxt   = '0;
        prog_nxt  = '0;
        body_nxt  = 1'b0;
        sat_nxt   = 1'b0;
      end else begin
        off_nxt = at_lim ? off_r : off_r + 1'b1;
      end
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_start_nxt = out_start_r;
    out_end_nxt   = out_end_r;
    out_long_nxt  = out_long_r;
    if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (take && emit) begin
      out_valid_nxt = 1'b1;
      out_start_nxt = StartW'(begin_r);
      out_end_nxt   = EndW'(emit_end);
      out_long_nxt  = sat_r || at_lim;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PhIdle;
      begin_r     <= '0;
      off_r       <= '0;
      prog_r      <= '0;
      body_r      <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      begin_r     <= begin_nxt;
      off_r       <= off_nxt;
      prog_r      <= prog_nxt;
      body_r      <= body_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_start_r <= out_start_nxt;
    out_end_r   <= out_end_nxt;
    out_long_r  <= out_long_nxt;
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.span_start = out_start_r;
  assign out_bus.span_end   = out_end_r;
  assign out_bus.long_line  = out_long_r;

  // Checks
  `MSS_ASSERT_ALWAYS(a_prog_range, prog_r < MacroProgW'(MacroLen), "macro progress overrun")
  `MSS_ASSERT_ALWAYS(a_off_range, off_r <= OffW'(LINE_POSITIONS), "line offset past limit")
  `MSS_ASSERT_NEXT(a_line_clear, take && cl.last, (off_r == '0) && !sat_r, "line not cleared")
  `MSS_ASSERT_NEXT(a_line_idle, take && cl.last, phase_r == PhIdle, "phase not idle")
  `MSS_ASSERT_NEXT(a_emit_shown, take && emit, out_valid_r, "found span not presented")

endmodule
`default_nettype wire

/* rtl/core/mangled_symbol_scanner.sv */
// Top level of the mangled symbol scanner.
//
//   channel   dir   payload                               beat on
//   in_bus    in    char_byte[7:0], line_end              valid && ready
//   out_bus   out   span_start[11:0], span_end[12:0],     valid && ready
//                   long_line
//
// One byte per cycle sustained while results are taken; each byte is classified
// on entry, waits in a two-entry queue and is scanned by the core.
// A found span is in the result register in the cycle after the core takes
// the byte that closes it; at most one result per byte.
// Reset is synchronous, active low, and returns the scan to the idle phase.
// A stalled result holds the core; the queue then fills and in_bus.ready drops.
`timescale 1ns / 1ps
`default_nettype none
module mangled_symbol_scanner #(
  parameter int LINE_POSITIONS = msscan_pkg::LinePositionsDef
) (
  input  logic          clk,
  input  logic          rst_n,
  msscan_in_if.sink     in_bus,
  msscan_out_if.source  out_bus
);
  import msscan_pkg::*;

  logic push_valid;
  cls_t push_data;
  logic push_ready;
  logic pop_valid;
  cls_t pop_data;
  logic pop_ready;

  msscan_front u_front (
    .in_bus     (in_bus),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  msscan_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  msscan_back #(
    .LINE_POSITIONS (LINE_POSITIONS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .out_bus   (out_bus)
  );

endmodule
`default_nettype wire

/* test/mangled_symbol_scanner_checker.sv */
// Span predictor and scoreboard that watches both channels of the mangled symbol scanner.
`timescale 1ns / 1ps
module mangled_symbol_scanner_checker
  import msscan_pkg::*;
#(
  parameter int LinePos = LinePositionsDef
) (
  input  logic  clk,
  input  logic  rst_n,
  msscan_in_if  in_mon,
  msscan_out_if out_mon,
  output int    spans_pending,
  output int    fail_count
);

  typedef struct packed {
    logic [StartW-1:0] first_pos;
    logic [EndW-1:0]   past_pos;
    logic              long_line;
  } span_t;

  localparam logic [EndW-1:0]   PosLimit = EndW'(LinePos);
  localparam logic [StartW-1:0] PosLast  = StartW'(LinePos - 1);

  // predicted scanner state
  phase_t                scan_ph;
  logic [StartW-1:0]     cand_start;
  logic [EndW-1:0]       line_pos;
  logic [MacroProgW-1:0] macro_cnt;
  logic                  body_seen;
  logic                  line_sat;

  span_t span_q[$];
  int    errs;

  initial begin
    spans_pending = 0;
    fail_count    = 0;
    errs          = 0;
  end

  function automatic void clear_line();
    scan_ph    = PhIdle;
    cand_start = '0;
    line_pos   = '0;
    macro_cnt  = '0;
    body_seen  = 1'b0;
    line_sat   = 1'b0;
  endfunction

  // letters, digits, '_', '$' and '.'
  function automatic bit is_body(input logic [7:0] ch);
    return ch == ChUnder || ch == ChDollar || ch == ChDot ||
           (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A) ||
           (ch >= 8'h30 && ch <= 8'h39);
  endfunction

  // Advance the predicted state by one byte; returns 1 when a span closes.
  function automatic bit scan_byte(input logic [7:0] ch, input logic last, output span_t sp);
    logic [EndW-1:0]   off;
    logic [EndW-1:0]   stop;
    logic [StartW-1:0] pos;
    bit                taken;
    bit                at_seen;
    bit                hit;
    off     = line_pos;
    taken   = 1'b0;
    at_seen = 1'b0;
    hit     = 1'b0;
    sp      = '0;

    // saturate offsets on long lines
    if (off >= PosLimit) begin
      off      = PosLimit;
      line_sat = 1'b1;
    end
    pos = (off >= PosLimit) ? PosLast : off[StartW-1:0];

    // body bytes extend a found prefix; anything else closes it
    if (scan_ph == PhFound) begin
      if (is_body(ch)) begin
        body_seen = 1'b1;
        taken     = 1'b1;
      end else begin
        if (body_seen) begin
          sp  = '{cand_start, off, line_sat};
          hit = 1'b1;
        end
        scan_ph   = PhIdle;
        body_seen = 1'b0;
      end
    end

    // prefix search; the closing byte is rescanned from idle
    if (!taken) begin
      case (scan_ph)
        PhIdle: begin
          if (ch == ChUnder) begin
            scan_ph    = PhUnder;
            cand_start = pos;
          end else if (ch == ChDollar) begin
            scan_ph    = PhDollar;
            cand_start = pos;
          end else if (ch == ChAt) begin
            at_seen = 1'b1;
          end
        end
        PhUnder: begin
          if (ch == ChBigT) begin
            scan_ph   = PhFound;
            body_seen = 1'b0;
          end else if (ch == ChDollar) begin
            scan_ph = PhDollar;
          end else if (ch == ChUnder) begin
            cand_start = pos;
          end else begin
            scan_ph = PhIdle;
          end
        end
        default: begin
          if (ch == ChBigS || ch == ChSmallS || ch == ChSmallE) begin
            scan_ph   = PhFound;
            body_seen = 1'b0;
          end else if (ch == ChUnder) begin
            scan_ph    = PhUnder;
            cand_start = pos;
          end else if (ch == ChDollar) begin
            cand_start = pos;
          end else begin
            scan_ph = PhIdle;
          end
        end
      endcase
    end

    // macro prefix matcher runs beside the phase machine
    if (at_seen) begin
      macro_cnt = 1;
    end else if (macro_cnt != 0 && macro_cnt < MacroLen && ch == MacroPat[macro_cnt]) begin
      macro_cnt = macro_cnt + 1'b1;
    end else begin
      macro_cnt = '0;
    end

    // a completed macro prefix takes over the phase
    if (macro_cnt == MacroLen) begin
      macro_cnt = '0;
      scan_ph   = PhFound;
      body_seen = 1'b0;
      if (line_sat) begin
        cand_start = PosLast;
      end else if (off >= EndW'(MacroLen - 1)) begin
        stop       = off - EndW'(MacroLen - 1);
        cand_start = stop[StartW-1:0];
      end else begin
        cand_start = '0;
      end
    end

    // line end flushes an open span and clears the line state
    if (last) begin
      if (!hit && scan_ph == PhFound && body_seen) begin
        stop = (off >= PosLimit) ? PosLimit : off + 1'b1;
        sp   = '{cand_start, stop, line_sat};
        hit  = 1'b1;
      end
      clear_line();
    end else begin
      line_pos = (off < PosLimit) ? off + 1'b1 : PosLimit;
    end
    return hit;
  endfunction

  // result beats are checked before the same edge's input beat is predicted
  always @(posedge clk) begin : watch
    span_t got;
    span_t want;
    span_t pred;
    if (!rst_n) begin
      clear_line();
      span_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.span_start, out_mon.span_end, out_mon.long_line};
        if (span_q.size() == 0) begin
          $error("span beat with none expected: span_start %0d span_end %0d long_line %0d",
                 got.first_pos, got.past_pos, got.long_line);
          errs++;
        end else begin
          want = span_q.pop_front();
          if (got.first_pos !== want.first_pos) begin
            $error("span_start: expected %0d, actual %0d", want.first_pos, got.first_pos);
            errs++;
          end
          if (got.past_pos !== want.past_pos) begin
            $error("span_end: expected %0d, actual %0d", want.past_pos, got.past_pos);
            errs++;
          end
          if (got.long_line !== want.long_line) begin
            $error("long_line: expected %0d, actual %0d", want.long_line, got.long_line);
            errs++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (scan_byte(in_mon.char_byte, in_mon.line_end, pred)) span_q.push_back(pred);
      end
    end
    spans_pending <= span_q.size();
    fail_count    <= errs;
  end

endmodule

/* test/mangled_symbol_scanner_tb.sv */
// Top of the mangled symbol scanner testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps
module mangled_symbol_scanner_tb;
  import msscan_pkg::*;

  localparam int LinePositions = LinePositionsDef;
  localparam int ItemsPerPhase = 420;
  localparam int QuietLimit    = 3000;
  localparam int IdlePct  [4]  = '{0, 86, 0, 26};
  localparam int StallPct [4]  = '{0, 0, 86, 26};

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   stall_pct;
  int   quiet;
  int   spans_pending;
  int   fail_count;
  logic [7:0] line_q[$];

  msscan_in_if  in_bus ();
  msscan_out_if out_bus ();

  mangled_symbol_scanner #(.LINE_POSITIONS(LinePositions)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  mangled_symbol_scanner_checker #(.LinePos(LinePositions)) chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .spans_pending (spans_pending),
    .fail_count    (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // watchdog: too long without any beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [7:0] body_char();
    string set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_$.";
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  // first n bytes of the macro prefix
  task automatic add_macro(input int n);
    for (int i = 0; i < n; i++) line_q.push_back(MacroPat[i]);
  endtask

  task automatic add_token();
    int    n;
    string seps = " ,;:()";
    case ($urandom_range(0, 11))
      0, 1, 2, 3: begin
        // prefix after a short '_'/'$' run, body sometimes empty
        n = $urandom_range(0, 2);
        repeat (n) line_q.push_back($urandom_range(0, 1) ? ChUnder : ChDollar);
        case ($urandom_range(0, 4))
          0:       add_text("_T");
          1:       add_text("$S");
          2:       add_text("$s");
          3:       add_text("$e");
          default: add_text("_$e");
        endcase
        n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        repeat (n) line_q.push_back(body_char());
      end
      4, 5: begin
        // macro prefix, whole with a body that may be empty or cut short by a stray byte
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, MacroLen - 1) : MacroLen;
        add_macro(n);
        if (n < MacroLen) line_q.push_back(8'($urandom_range(0, 255)));
        else repeat ($urandom_range(0, 6)) line_q.push_back(body_char());
      end
      6: repeat ($urandom_range(1, 3)) line_q.push_back(8'($urandom_range(0, 255)));
      7: line_q.push_back(seps[$urandom_range(0, seps.len() - 1)]);
      8: repeat ($urandom_range(1, 6)) line_q.push_back(body_char());
      9: repeat ($urandom_range(1, 4)) line_q.push_back($urandom_range(0, 1) ? ChUnder : ChDollar);
      10: begin
        // '@' right after '_' is swallowed and never starts a macro
        line_q.push_back(ChUnder);
        add_macro(MacroLen);
        line_q.push_back(body_char());
      end
      default: begin
        line_q.push_back(ChAt);
        line_q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // one beat; called at a falling edge, returns at the falling edge after acceptance
  task automatic send_beat(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.char_byte <= b;
    in_bus.line_end  <= last;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_beat(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (spans_pending != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int sent;
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.char_byte = '0;
    in_bus.line_end  = 1'b0;
    out_bus.ready    = 1'b0;
    idle_pct         = 0;
    stall_pct        = 0;
    quiet            = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed lines
    add_text("_$sZ");          // closed by 0xFF, start stays at the '_'
    line_q.push_back(8'hFF);
    send_line();
    add_text("_T");            // empty body at line end
    send_line();
    add_text("$e9 ");          // closed by a space
    send_line();
    add_text("_x$S");          // swallowed byte, then empty body closed by 0x00
    line_q.push_back(8'h00);
    send_line();
    add_macro(MacroLen);       // macro prefix ending on the line end
    send_line();
    add_text("$Sab");          // span closed by the line end
    send_line();
    drain();

    // random lines over the idle and stall phases
    for (int p = 0; p < 4; p++) begin
      idle_pct  = IdlePct[p];
      stall_pct = StallPct[p];
      sent      = 0;
      while (sent < ItemsPerPhase) begin
        repeat ($urandom_range(1, 6)) add_token();
        sent += line_q.size();
        send_line();
      end
      drain();
    end

    // settle, then look for stray spans
    stall_pct = 0;
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* mangled_symbol_scanner.f */
+incdir+rtl/core
rtl/core/msscan_pkg.sv
rtl/core/msscan_if.sv
rtl/core/msscan_front.sv
rtl/core/msscan_fifo.sv
rtl/core/msscan_back.sv
rtl/core/mangled_symbol_scanner.sv
test/mangled_symbol_scanner_checker.sv
test/mangled_symbol_scanner_tb.sv
